[hdl/pds_pkg.sv]
// Shared widths, limits and handshake structs for the PLL divider search.
package pds_pkg;

    // Field widths of the stream payload
    localparam int REQ_W       = 33;
    localparam int SRC_W       = 32;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 96;

    // Internal datapath widths
    localparam int PC_W   = 30;
    localparam int QUOT_W = 30;
    localparam int R_W    = 7;
    localparam int M_W    = 17;
    localparam int MUL_A_W = 32;
    localparam int PROD_W = MUL_A_W + M_W;
    localparam int VT_W   = 33;
    localparam int DIFF_W = PROD_W + 1;

    // Shared divider widths
    localparam int DIV_W  = 53;
    localparam int DVS_W  = 30;
    localparam int STEP_W = 6;

    // Largest reference divider tried by default
    localparam int MAX_REF_DIV_DEF = 64;

    // Request from the sequencer to the divider
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DIV_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
    } t_div_req;

    // Response from the divider
    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

[hdl/pds_divider.sv]
// Restoring divider, one quotient bit per cycle, dividend aligned to the top by the caller.
module pds_divider
    import pds_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_W-1:0]  r_acc;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_div;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DVS_W:0]    part;
    logic [DVS_W+1:0]  diff;
    logic              fits;

    // Trial subtract of the divisor from the partial remainder
    assign part = {r_rem, r_acc[DIV_W-1]};
    assign diff = {1'b0, part} - {2'b00, r_div};
    assign fits = ~diff[DVS_W+1];

    // Control: load on start, count the steps down, pulse done at the end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_req.steps;
        end else if (r_busy) begin
            r_cnt <= STEP_W'(r_cnt - 1'b1);
            if (r_cnt == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath: shift dividend bits out of the top, quotient bits in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_acc <= {r_acc[DIV_W-2:0], fits};
            r_rem <= fits ? diff[DVS_W-1:0] : part[DVS_W-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_acc;

endmodule

[hdl/pll_divider_search.sv]
// Top level of the PLL divider search: sequencer, shared multiplier and output register.
//
// Each transaction on the slave side carries a target rate and a reference rate and
// yields one transaction on the master side with the chosen divider settings. The block
// takes one item at a time: it is ready only while idle. The search tries the reference
// dividers in turn and stops early when a later divider brings the reference below 7 MHz.
// At most MAX_REF_DIV less the smallest legal divider plus one dividers are tried; with
// MAX_REF_DIV at 64 that is at most 64 dividers. The search time is set by the single
// bit-per-cycle divider, which runs one 53-step division for the VCO ratio, one 30-step
// division per candidate divider and one 53-step division for the achieved rate. A
// finished result waits in the output register while the next item is accepted.
module pll_divider_search
    import pds_pkg::*;
#(
    parameter int MAX_REF_DIV = MAX_REF_DIV_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Slave side: [32:0] target_rate, [64:33] ref_rate, rest zero
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // Master side: [5:0] ref_div_field, [14:6] mult_field, [17:15] post_shift,
    // [20:18] filter_range, [46:21] pll_word, [89:47] achieved_rate, rest zero
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // Master side user: [0] parent_clamped
    output logic                   o_m_tuser
);

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PREP = 4'd1;
    localparam logic [3:0] S_QUOT = 4'd2;
    localparam logic [3:0] S_FR   = 4'd3;
    localparam logic [3:0] S_M0   = 4'd4;
    localparam logic [3:0] S_M1   = 4'd5;
    localparam logic [3:0] S_V0   = 4'd6;
    localparam logic [3:0] S_V1   = 4'd7;
    localparam logic [3:0] S_V2   = 4'd8;
    localparam logic [3:0] S_D0   = 4'd9;
    localparam logic [3:0] S_D1   = 4'd10;
    localparam logic [3:0] S_FIN1 = 4'd11;
    localparam logic [3:0] S_FIN2 = 4'd12;
    localparam logic [3:0] S_RATE = 4'd13;
    localparam logic [3:0] S_EMIT = 4'd14;

    // Frequency limits
    localparam logic [SRC_W-1:0] PAR_CEIL   = SRC_W'(600000000);
    localparam logic [SRC_W-1:0] PAR_FLOOR  = SRC_W'(7000000);
    localparam logic [PC_W-1:0]  REF_FLOOR  = PC_W'(7000000);
    localparam logic [PC_W-1:0]  LO_STEP1   = PC_W'(200000000);
    localparam logic [PC_W-1:0]  LO_STEP2   = PC_W'(400000000);
    localparam logic [VT_W-1:0]  VCO_TOP    = VT_W'(64'd4800000000);
    localparam logic [VT_W-1:0]  VCO_HALF   = VT_W'(64'd2400000000);
    // Target thresholds for the post-divider shift
    localparam logic [REQ_W-1:0] REQ_SHIFT6 = REQ_W'(73846153);
    localparam logic [REQ_W-1:0] REQ_Q6     = REQ_W'(75000000);
    localparam logic [REQ_W-1:0] REQ_Q5     = REQ_W'(150000000);
    localparam logic [REQ_W-1:0] REQ_Q4     = REQ_W'(300000000);
    localparam logic [REQ_W-1:0] REQ_Q3     = REQ_W'(600000000);
    localparam logic [REQ_W-1:0] REQ_Q2     = REQ_W'(1200000000);
    localparam logic [REQ_W-1:0] REQ_Q1     = REQ_W'(64'd2400000000);
    // Divider step counts and alignment
    localparam logic [STEP_W-1:0] STEPS_FULL = STEP_W'(DIV_W);
    localparam logic [STEP_W-1:0] STEPS_REF  = STEP_W'(PC_W);
    localparam int               VT_SHIFT   = 20;
    localparam int               M_ROUND    = 20;
    localparam int               M_SHIFT    = 21;

    // Jitter filter range from the divided reference
    function automatic logic [2:0] pick_filter(input logic [PC_W-1:0] fr);
        logic [2:0] a;
        if      (fr < PC_W'(11000000))  a = 3'd1;
        else if (fr < PC_W'(18000000))  a = 3'd2;
        else if (fr < PC_W'(30000000))  a = 3'd3;
        else if (fr < PC_W'(50000000))  a = 3'd4;
        else if (fr < PC_W'(80000000))  a = 3'd5;
        else if (fr < PC_W'(130000000)) a = 3'd6;
        else                            a = 3'd7;
        return a;
    endfunction

    logic [3:0]        r_state;
    logic [3:0]        n_state;

    logic [REQ_W-1:0]  r_req;
    logic [SRC_W-1:0]  r_src;
    logic [PC_W-1:0]   r_pc;
    logic              r_clamp;
    logic [2:0]        r_q;
    logic [VT_W-1:0]   r_vt;
    logic [R_W-1:0]    r_lo;
    logic [R_W-1:0]    r_r;
    logic [QUOT_W-1:0] r_quot;
    logic [PC_W-1:0]   r_fr;
    logic [M_W-1:0]    r_m;
    logic [PROD_W-1:0] r_prod;
    logic [DIFF_W-1:0] r_d;
    logic [VT_W-1:0]   r_win_d;
    logic [R_W-1:0]    r_win_r;
    logic [M_W-1:0]    r_win_m;
    logic [PC_W-1:0]   r_win_fr;
    logic [M_W-1:0]    r_first_m;
    logic [PC_W-1:0]   r_first_fr;
    logic [2:0]        r_filt;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_user;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [PC_W-1:0]    pc_c;
    logic               clamp_c;
    logic [2:0]         q_c;
    logic [VT_W-1:0]    vt_c;
    logic [R_W-1:0]     lo_c;
    logic               stop_c;
    logic               fr_low_c;
    logic [MUL_A_W-1:0] mul_a;
    logic [M_W-1:0]     mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [DIFF_W-1:0]  v_c;
    logic [DIFF_W-1:0]  vt_ext;
    logic [M_W-1:0]     m_adj;
    logic [R_W-1:0]     eff_r;
    logic [M_W-1:0]     eff_m;
    logic [PC_W-1:0]    eff_fr;
    logic               out_free;
    logic [5:0]         rf_c;
    logic [8:0]         mf_c;
    logic [25:0]        word_c;
    logic [42:0]        rate_c;

    // Clamp the reference and pick the lowest legal divider
    always_comb begin
        clamp_c = 1'b0;
        pc_c    = PC_W'(r_src);
        if (r_src > PAR_CEIL) begin
            pc_c    = PC_W'(PAR_CEIL);
            clamp_c = 1'b1;
        end
        if (r_src < PAR_FLOOR) begin
            pc_c    = REF_FLOOR;
            clamp_c = 1'b1;
        end
        if (pc_c <= LO_STEP1)      lo_c = R_W'(1);
        else if (pc_c <= LO_STEP2) lo_c = R_W'(2);
        else                       lo_c = R_W'(3);
    end

    // Post-divider shift and VCO target from the request
    always_comb begin
        if (r_req > REQ_Q1) begin
            q_c  = 3'd1;
            vt_c = VCO_TOP;
        end else if (r_req <= REQ_SHIFT6) begin
            q_c  = 3'd6;
            vt_c = VCO_HALF;
        end else begin
            if      (r_req <= REQ_Q6) q_c = 3'd6;
            else if (r_req <= REQ_Q5) q_c = 3'd5;
            else if (r_req <= REQ_Q4) q_c = 3'd4;
            else if (r_req <= REQ_Q3) q_c = 3'd3;
            else if (r_req <= REQ_Q2) q_c = 3'd2;
            else                      q_c = 3'd1;
            vt_c = VT_W'((REQ_W + 6)'(r_req) << q_c);
        end
    end

    // Loop exits and winner fallback
    assign stop_c   = (r_r >= R_W'(MAX_REF_DIV));
    assign fr_low_c = (r_r != r_lo) && (div_rsp.quotient[PC_W-1:0] < REF_FLOOR);
    assign eff_r    = (r_win_r == '0) ? r_lo       : r_win_r;
    assign eff_m    = (r_win_r == '0) ? r_first_m  : r_win_m;
    assign eff_fr   = (r_win_r == '0) ? r_first_fr : r_win_fr;

    // Shared multiplier operand selection
    always_comb begin
        case (r_state)
            S_M0: begin
                mul_a = MUL_A_W'(r_quot);
                mul_b = M_W'(r_r);
            end
            S_V0, S_V2: begin
                mul_a = MUL_A_W'(r_fr);
                mul_b = r_m;
            end
            S_FIN1: begin
                mul_a = r_src;
                mul_b = eff_m;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Multiplier adjustment from the first VCO estimate
    assign v_c    = {r_prod, 1'b0};
    assign vt_ext = DIFF_W'(r_vt);
    always_comb begin
        m_adj = r_m;
        if (v_c > vt_ext && r_m != '0) m_adj = M_W'(m_adj - 1'b1);
        if (v_c < DIFF_W'(VCO_HALF))   m_adj = M_W'(m_adj + 1'b1);
    end

    // Divider requests
    always_comb begin
        div_req.start    = 1'b0;
        div_req.steps    = STEPS_REF;
        div_req.dividend = {r_pc, (DIV_W - PC_W)'(0)};
        div_req.divisor  = DVS_W'(r_r);
        case (r_state)
            S_PREP: begin
                div_req.start    = 1'b1;
                div_req.steps    = STEPS_FULL;
                div_req.dividend = {vt_c, VT_SHIFT'(0)};
                div_req.divisor  = DVS_W'(pc_c);
            end
            S_QUOT: begin
                div_req.start = div_rsp.done;
            end
            S_D1: begin
                div_req.start   = ~stop_c;
                div_req.divisor = DVS_W'(R_W'(r_r + 1'b1));
            end
            S_FIN2: begin
                div_req.start    = 1'b1;
                div_req.steps    = STEPS_FULL;
                div_req.dividend = DIV_W'({r_prod, 1'b0});
                div_req.divisor  = DVS_W'(r_win_r);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    pds_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Next state
    assign out_free = ~r_out_valid | i_m_tready;
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_s_tvalid) n_state = S_PREP;
            S_PREP: n_state = S_QUOT;
            S_QUOT: if (div_rsp.done) n_state = S_FR;
            S_FR: begin
                if (div_rsp.done) n_state = fr_low_c ? S_FIN1 : S_M0;
            end
            S_M0:   n_state = S_M1;
            S_M1:   n_state = S_V0;
            S_V0:   n_state = S_V1;
            S_V1:   n_state = S_V2;
            S_V2:   n_state = S_D0;
            S_D0:   n_state = S_D1;
            S_D1:   n_state = stop_c ? S_FIN1 : S_FR;
            S_FIN1: n_state = S_FIN2;
            S_FIN2: n_state = S_RATE;
            S_RATE: if (div_rsp.done) n_state = S_EMIT;
            S_EMIT: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Search datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    r_req <= i_s_tdata[REQ_W-1:0];
                    r_src <= i_s_tdata[REQ_W +: SRC_W];
                end
            end
            S_PREP: begin
                r_pc     <= pc_c;
                r_clamp  <= clamp_c;
                r_q      <= q_c;
                r_vt     <= vt_c;
                r_lo     <= lo_c;
                r_r      <= lo_c;
                r_win_d  <= VCO_TOP;
                r_win_r  <= '0;
                r_win_m  <= '0;
                r_win_fr <= '0;
            end
            S_QUOT: begin
                if (div_rsp.done) r_quot <= div_rsp.quotient[QUOT_W-1:0];
            end
            S_FR: begin
                if (div_rsp.done) r_fr <= div_rsp.quotient[PC_W-1:0];
            end
            S_M0, S_V0, S_V2: begin
                r_prod <= mul_p;
            end
            S_M1: begin
                r_m <= M_W'((DIFF_W'(r_prod) + (DIFF_W'(1) << M_ROUND)) >> M_SHIFT);
            end
            S_V1: begin
                r_m <= m_adj;
            end
            S_D0: begin
                r_d <= (vt_ext > v_c) ? DIFF_W'(vt_ext - v_c) : DIFF_W'(v_c - vt_ext);
            end
            S_D1: begin
                // Keep the first candidate for the fallback, the closest as the winner
                if (r_r == r_lo) begin
                    r_first_m  <= r_m;
                    r_first_fr <= r_fr;
                end
                if (r_d < DIFF_W'(r_win_d)) begin
                    r_win_d  <= VT_W'(r_d);
                    r_win_r  <= r_r;
                    r_win_m  <= r_m;
                    r_win_fr <= r_fr;
                end
                if (!stop_c) r_r <= R_W'(r_r + 1'b1);
            end
            S_FIN1: begin
                r_win_r <= eff_r;
                r_win_m <= eff_m;
                r_filt  <= pick_filter(eff_fr);
                r_prod  <= mul_p;
            end
            default: begin
                r_m <= r_m;
            end
        endcase
    end

    // Pack the result fields
    assign rf_c   = 6'(R_W'(r_win_r - 1'b1));
    assign mf_c   = (r_win_m != '0) ? 9'(M_W'(r_win_m - 1'b1)) : 9'd0;
    assign word_c = {5'b10000, r_filt, r_q, mf_c, rf_c};
    assign rate_c = 43'(div_rsp.quotient >> r_q);

    // Output register: load when free, drop valid once the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_out_data <= OUT_TDATA_W'({rate_c, word_c, r_filt, r_q, mf_c, rf_c});
            r_out_user <= r_clamp;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

[test/pll_divider_search_tb.sv]
// Testbench for the PLL divider search: corner and random requests checked by a scoreboard.
`timescale 1ns / 1ps

module pll_divider_search_tb
    import pds_pkg::*;
();

    // Frequency limits of the search, in Hz
    localparam bit [63:0] REF_MIN_HZ     = 64'd7000000;
    localparam bit [63:0] DIV_REF_MAX_HZ = 64'd200000000;
    localparam bit [63:0] REF_MAX_HZ     = 64'd600000000;
    localparam bit [63:0] VCO_MAX_HZ     = 64'd4800000000;
    localparam bit [63:0] MAX_RATIO      = 64'd64;
    localparam bit [25:0] INT_FEEDBACK   = 26'd1 << 25;

    localparam int RANDOM_ITEMS  = 219;
    localparam int PLANNED_ITEMS = RANDOM_ITEMS + 21;
    localparam int DRAIN_CYCLES  = 3000;
    localparam int REPORT_LIMIT  = 10;

    // Jitter filter range codes, one per band of the divided reference
    typedef enum bit [2:0] {
        FILT_UNDER_11M  = 3'd1,
        FILT_UNDER_18M  = 3'd2,
        FILT_UNDER_30M  = 3'd3,
        FILT_UNDER_50M  = 3'd4,
        FILT_UNDER_80M  = 3'd5,
        FILT_UNDER_130M = 3'd6,
        FILT_TOP        = 3'd7
    } t_filter_code;

    // One expected PLL setting
    typedef struct packed {
        bit [5:0]     ref_div;
        bit [8:0]     mult;
        bit [2:0]     shift;
        t_filter_code filt;
        bit [25:0]    word;
        bit [42:0]    rate;
        bit           clamped;
    } t_pll_setting;

    // Scoreboard: predicts the setting for each accepted request and checks results in order
    class pll_result_board;
        t_pll_setting settings_due[$];
        int           mismatches = 0;

        function t_filter_code filter_band(bit [63:0] fr);
            if (fr < 64'd11000000)  return FILT_UNDER_11M;
            if (fr < 64'd18000000)  return FILT_UNDER_18M;
            if (fr < 64'd30000000)  return FILT_UNDER_30M;
            if (fr < 64'd50000000)  return FILT_UNDER_50M;
            if (fr < 64'd80000000)  return FILT_UNDER_80M;
            if (fr < 64'd130000000) return FILT_UNDER_130M;
            return FILT_TOP;
        endfunction

        function t_pll_setting search_setting(bit [32:0] target, bit [31:0] parent);
            t_pll_setting s;
            bit [63:0]    req, src, pc, ratio, shift, vco_goal, quot, lo, hi, r;
            bit [63:0]    best_r, best_m, best_gap, first_m, m, fr, v, gap, rate;
            req       = 64'(target);
            src       = 64'(parent);
            pc        = src;
            s.clamped = 1'b0;
            // Clamp the reference into its legal band
            if (pc > REF_MAX_HZ) begin
                pc        = REF_MAX_HZ;
                s.clamped = 1'b1;
            end
            if (pc < REF_MIN_HZ) begin
                pc        = REF_MIN_HZ;
                s.clamped = 1'b1;
            end
            // Post-divider shift and VCO goal from the ratio of VCO maximum to request
            ratio = (req != 0) ? VCO_MAX_HZ / req : '1;
            if (ratio <= 1) begin
                shift    = 1;
                vco_goal = VCO_MAX_HZ;
            end else if (ratio > MAX_RATIO) begin
                shift    = 6;
                vco_goal = VCO_MAX_HZ / 2;
            end else begin
                shift = 0;
                while ((64'd2 << shift) <= ratio) shift++;
                vco_goal = req << shift;
            end
            quot = (vco_goal << 20) / pc;
            // Range of reference dividers keeping the divided reference in band
            lo = (pc + DIV_REF_MAX_HZ - 1) / DIV_REF_MAX_HZ;
            hi = pc / REF_MIN_HZ;
            if (hi > 64'(MAX_REF_DIV_DEF)) hi = 64'(MAX_REF_DIV_DEF);
            if (hi < lo) hi = lo;
            best_r   = 0;
            best_m   = 0;
            best_gap = VCO_MAX_HZ;
            first_m  = 0;
            // Try every divider; keep the smallest VCO error, smaller divider on a tie
            for (r = lo; r <= hi; r++) begin
                m  = (quot * r + (64'd1 << 20)) >> 21;
                fr = pc / r;
                v  = fr * m * 2;
                if (v > vco_goal && m > 0) m--;
                if (v < VCO_MAX_HZ / 2) m++;
                v   = fr * m * 2;
                gap = (vco_goal > v) ? vco_goal - v : v - vco_goal;
                if (r == lo) first_m = m;
                if (gap < best_gap) begin
                    best_gap = gap;
                    best_r   = r;
                    best_m   = m;
                end
            end
            if (best_r == 0) begin
                best_r = lo;
                best_m = first_m;
            end
            s.ref_div = 6'(best_r - 1);
            s.mult    = 9'((best_m > 0) ? best_m - 1 : 64'd0);
            s.shift   = 3'(shift);
            s.filt    = filter_band(pc / best_r);
            s.word    = 26'({s.filt, s.shift, s.mult, s.ref_div}) | INT_FEEDBACK;
            rate      = ((src * 2 * best_m) / best_r) >> shift;
            s.rate    = 43'(rate);
            return s;
        endfunction

        function void note_request(bit [32:0] target, bit [31:0] parent);
            settings_due.push_back(search_setting(target, parent));
        endfunction

        function void compare_field(string name, bit [63:0] exp_val, bit [63:0] act_val);
            if (exp_val != act_val) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: %s mismatch: expected %0d, got %0d",
                             $realtime, name, exp_val, act_val);
            end
        endfunction

        function void check_result(bit [OUT_TDATA_W-1:0] data, bit user);
            t_pll_setting e;
            if (settings_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result with nothing expected: tdata %h tuser %b",
                             $realtime, data, user);
                return;
            end
            e = settings_due.pop_front();
            compare_field("ref_div_field",  e.ref_div, data[5:0]);
            compare_field("mult_field",     e.mult,    data[14:6]);
            compare_field("post_shift",     e.shift,   data[17:15]);
            compare_field("filter_range",   e.filt,    data[20:18]);
            compare_field("pll_word",       e.word,    data[46:21]);
            compare_field("achieved_rate",  e.rate,    data[89:47]);
            compare_field("parent_clamped", e.clamped, user);
        endfunction
    endclass

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tuser;

    pll_result_board board;
    int              items_sent    = 0;
    int              src_idle_pct  = 13;
    int              sink_idle_pct = 77;

    pll_divider_search u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Send one request, idling first at random, and note it once accepted
    task automatic send_request(input bit [32:0] target, input bit [31:0] parent);
        if (items_sent < PLANNED_ITEMS / 3) begin
            src_idle_pct  = 13;
            sink_idle_pct = 77;
        end else if (items_sent < 2 * PLANNED_ITEMS / 3) begin
            src_idle_pct  = 77;
            sink_idle_pct = 13;
        end else begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
        end
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(IN_TDATA_W - REQ_W - SRC_W){1'b0}}, parent, target};
        do @(posedge i_clk); while (!o_s_tready);
        board.note_request(target, parent);
        items_sent++;
    endtask

    // Check each result transaction and stall the master side at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_result(o_m_tdata, o_m_tuser);
        i_m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Stimulus: corner cases first, then random requests
    initial begin
        bit [32:0] target;
        bit [31:0] parent;
        bit [63:0] wide;
        int        pick;
        board = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(33'd1, 32'd7000000);
        send_request(33'd0, 32'd25000000);
        send_request(33'd4800000000, 32'd600000000);
        send_request('1, 32'd600000000);
        send_request(33'd2400000000, 32'd100000000);
        send_request(33'd2400000001, 32'd100000000);
        send_request(33'd75000000, 32'd27000000);
        send_request(33'd73846153, 32'd27000000);
        send_request(33'd148500000, 32'd0);
        send_request(33'd148500000, 32'd6999999);
        send_request(33'd148500000, 32'd7000000);
        send_request(33'd100000000, 32'd10999999);
        send_request(33'd100000000, 32'd11000000);
        send_request(33'd1000000000, 32'd200000000);
        send_request(33'd1000000000, 32'd200000001);
        send_request(33'd500000000, 32'd600000000);
        send_request(33'd500000000, 32'd600000001);
        send_request(33'd33000000, '1);
        send_request(33'd1, '1);
        send_request(33'd4800000000, '1);
        send_request(33'd312500000, 32'd125000000);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Target: whole field, legal band, low rates, or near a shift boundary
            pick = $urandom_range(99);
            if (pick < 25) begin
                target = {1'($urandom_range(1, 0)), 32'($urandom())};
            end else if (pick < 65) begin
                wide   = {$urandom(), $urandom()};
                target = 33'(wide % VCO_MAX_HZ + 1);
            end else if (pick < 90) begin
                target = 33'($urandom_range(200000000, 1));
            end else begin
                target = 33'(VCO_MAX_HZ / 64'($urandom_range(70, 1))
                             + 64'($urandom_range(2, 0)) - 1);
            end
            // Parent: whole field, low band (short searches), full band, or near the clamps
            pick = $urandom_range(99);
            if (pick < 15)
                parent = $urandom();
            else if (pick < 55)
                parent = $urandom_range(100000000, 7000000);
            else if (pick < 85)
                parent = $urandom_range(600000000, 7000000);
            else if (pick < 93)
                parent = $urandom_range(7000000, 0);
            else
                parent = $urandom_range(700000000, 590000000);
            send_request(target, parent);
        end
        i_s_tvalid <= 1'b0;

        // Drain outstanding results, then allow for one more search latency
        while (board.settings_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.settings_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hold a hard limit on run time
    initial begin
        #(50_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
hdl/pds_pkg.sv
hdl/pds_divider.sv
hdl/pll_divider_search.sv
test/pll_divider_search_tb.sv
